// File: rtl/core/chained_hash_map_engine_assert.svh
// Assertion macros for the hash map engine
`ifndef CHAINED_HASH_MAP_ENGINE_ASSERT_SVH
`define CHAINED_HASH_MAP_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define CHME_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CHME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHME_ASSERT_SAME(lbl, ante, cons, msg)
`define CHME_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/chme_pkg.sv
package chme_pkg;

  localparam int unsigned BUCKETS_DEFAULT    = 256;
  localparam int unsigned POOL_NODES_DEFAULT = 1024;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned COUNT_W = 11;

  // request codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // result codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERWRITE = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_HEAD_RD,
    S_HEAD,
    S_WALK,
    S_ACT,
    S_ALLOC
  } seq_state_t;

  // one finished result word
  typedef struct packed {
    logic [1:0]         status;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

// File: rtl/core/chme_ram.sv
module chme_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/chme_seq.sv
module chme_seq #(
  parameter int unsigned BUCKETS    = chme_pkg::BUCKETS_DEFAULT,
  parameter int unsigned POOL_NODES = chme_pkg::POOL_NODES_DEFAULT,
  localparam int unsigned BW = $clog2(BUCKETS),
  localparam int unsigned IW = $clog2(POOL_NODES),
  localparam int unsigned NW = chme_pkg::KEY_W + chme_pkg::DATA_W + 1 + IW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic [chme_pkg::KEY_W-1:0]    key,
  input  logic [chme_pkg::DATA_W-1:0]   data_in,
  output logic                          res_valid,
  input  logic                          res_ready,
  output chme_pkg::result_t             res,
  // bucket head memory
  output logic                          b_we,
  output logic [BW-1:0]                 b_addr,
  output logic [IW:0]                   b_wdata,
  input  logic [IW:0]                   b_rdata,
  // node memory
  output logic                          n_we,
  output logic [IW-1:0]                 n_addr,
  output logic [NW-1:0]                 n_wdata,
  input  logic [NW-1:0]                 n_rdata,
  // free stack memory
  output logic                          f_we,
  output logic [IW-1:0]                 f_addr,
  output logic [IW-1:0]                 f_wdata,
  input  logic [IW-1:0]                 f_rdata
);

  localparam int unsigned SWEEP = (BUCKETS > POOL_NODES) ? BUCKETS : POOL_NODES;
  localparam int unsigned SW    = $clog2(SWEEP);
  localparam int unsigned CW    = IW + 1;
  localparam bit          POW2  = (BUCKETS & (BUCKETS - 1)) == 0;

  typedef struct packed {
    logic [chme_pkg::KEY_W-1:0]  key;
    logic [chme_pkg::DATA_W-1:0] data;
    logic                        lok;
    logic [IW-1:0]               link;
  } node_word_t;

  typedef struct packed {
    logic          ok;
    logic [IW-1:0] idx;
  } head_word_t;

  chme_pkg::seq_state_t state, state_next;

  logic [SW-1:0]               sweep;
  logic [1:0]                  op_r;
  logic [chme_pkg::KEY_W-1:0]  key_r;
  logic [chme_pkg::KEY_W-1:0]  kshift;
  logic [chme_pkg::DATA_W-1:0] data_r;
  logic [BW-1:0]               bkt;
  logic [2:0]                  hcnt;
  logic                        head_ok;
  logic [IW-1:0]               head_idx;
  logic [IW-1:0]               cur;
  logic                        prev_ok;
  logic [IW-1:0]               prev_idx;
  node_word_t                  prev_word;
  node_word_t                  hit_word;
  logic [IW-1:0]               hit;
  logic                        found;
  logic [CW-1:0]               free_top;
  logic [CW-1:0]               count;
  logic [1:0]                  st_r;
  logic [chme_pkg::DATA_W-1:0] dout_r;

  node_word_t nrd;
  head_word_t brd;
  logic [BW:0]   rstep;
  logic [BW-1:0] rem_next;
  logic          key_hit;
  logic          sweep_last;
  logic [31:0]   count32;

  assign nrd        = node_word_t'(n_rdata);
  assign brd        = head_word_t'(b_rdata);
  assign key_hit    = nrd.key == key_r;
  assign sweep_last = sweep == SW'(SWEEP - 1);

  // remainder by the bucket count, four key bits a step from the top
  always_comb begin
    rstep = {1'b0, bkt};
    for (int i = 0; i < 4; i++) begin
      rstep = {rstep[BW-1:0], kshift[chme_pkg::KEY_W-1-i]};
      if (rstep >= (BW+1)'(BUCKETS)) begin
        rstep = rstep - (BW+1)'(BUCKETS);
      end
    end
    rem_next = rstep[BW-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      chme_pkg::S_INIT:    if (sweep_last) state_next = chme_pkg::S_IDLE;
      chme_pkg::S_IDLE: begin
        if (in_valid) state_next = POW2 ? chme_pkg::S_HEAD_RD : chme_pkg::S_HASH;
      end
      chme_pkg::S_HASH:    if (hcnt == 3'd7) state_next = chme_pkg::S_HEAD_RD;
      chme_pkg::S_HEAD_RD: state_next = chme_pkg::S_HEAD;
      chme_pkg::S_HEAD: begin
        if (op_r == chme_pkg::OP_INSERT || op_r == chme_pkg::OP_REMOVE ||
            op_r == chme_pkg::OP_LOOKUP) begin
          state_next = brd.ok ? chme_pkg::S_WALK : chme_pkg::S_ACT;
        end else begin
          state_next = chme_pkg::S_ALLOC;
        end
      end
      chme_pkg::S_WALK:    if (key_hit || !nrd.lok) state_next = chme_pkg::S_ACT;
      chme_pkg::S_ACT: begin
        if (op_r == chme_pkg::OP_INSERT && !found && free_top != '0) begin
          state_next = chme_pkg::S_ALLOC;
        end else if (res_ready) begin
          state_next = chme_pkg::S_IDLE;
        end
      end
      chme_pkg::S_ALLOC:   if (res_ready) state_next = chme_pkg::S_IDLE;
      default:             state_next = chme_pkg::S_INIT;
    endcase
  end

  // memory ports and handshake
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    b_we      = 1'b0;
    b_addr    = bkt;
    b_wdata   = '0;
    n_we      = 1'b0;
    n_addr    = cur;
    n_wdata   = '0;
    f_we      = 1'b0;
    f_addr    = free_top[IW-1:0];
    f_wdata   = hit;
    case (state)
      chme_pkg::S_INIT: begin
        b_addr  = sweep[BW-1:0];
        b_we    = {1'b0, sweep} < (SW+1)'(BUCKETS);
        b_wdata = '0;
        f_addr  = sweep[IW-1:0];
        f_we    = {1'b0, sweep} < (SW+1)'(POOL_NODES);
        f_wdata = sweep[IW-1:0];
      end
      chme_pkg::S_IDLE: in_ready = 1'b1;
      chme_pkg::S_HEAD: n_addr = brd.idx;
      chme_pkg::S_WALK: n_addr = nrd.link;
      chme_pkg::S_ACT: begin
        // write-back stays pending until the result slot frees
        if (op_r == chme_pkg::OP_INSERT) begin
          if (!found && free_top != '0) begin
            f_addr = free_top[IW-1:0] - IW'(1);
          end else begin
            res_valid = 1'b1;
          end
        end else begin
          res_valid = 1'b1;
        end
      end
      chme_pkg::S_ALLOC: res_valid = 1'b1;
      default: ;
    endcase

    // commit writes on the cycle the result is handed over
    if (state == chme_pkg::S_ACT && res_ready && found) begin
      if (op_r == chme_pkg::OP_INSERT) begin
        n_we    = 1'b1;
        n_addr  = hit;
        n_wdata = {key_r, data_r, hit_word.lok, hit_word.link};
      end else if (op_r == chme_pkg::OP_REMOVE) begin
        if (prev_ok) begin
          n_we    = 1'b1;
          n_addr  = prev_idx;
          n_wdata = {prev_word.key, prev_word.data, hit_word.lok, hit_word.link};
        end else begin
          b_we    = 1'b1;
          b_wdata = {hit_word.lok, hit_word.link};
        end
        f_we   = free_top < CW'(POOL_NODES);
        f_addr = free_top[IW-1:0];
      end
    end
    if (state == chme_pkg::S_ALLOC && res_ready && op_r == chme_pkg::OP_INSERT) begin
      n_we    = 1'b1;
      n_addr  = f_rdata;
      n_wdata = {key_r, data_r, head_ok, head_idx};
      b_we    = 1'b1;
      b_wdata = {1'b1, f_rdata};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      chme_pkg::S_IDLE: begin
        op_r   <= op;
        key_r  <= key;
        kshift <= key;
        data_r <= data_in;
        bkt    <= POW2 ? key[BW-1:0] : '0;
        hcnt   <= '0;
      end
      chme_pkg::S_HASH: begin
        bkt    <= rem_next;
        kshift <= kshift << 4;
        hcnt   <= hcnt + 3'd1;
      end
      chme_pkg::S_HEAD: begin
        head_ok  <= brd.ok;
        head_idx <= brd.idx;
        cur      <= brd.idx;
        prev_ok  <= 1'b0;
        found    <= 1'b0;
      end
      chme_pkg::S_WALK: begin
        if (key_hit) begin
          found    <= 1'b1;
          hit      <= cur;
          hit_word <= nrd;
        end else begin
          prev_ok   <= 1'b1;
          prev_idx  <= cur;
          prev_word <= nrd;
          cur       <= nrd.link;
        end
      end
      default: ;
    endcase
  end

  // result code and data, settled before the handover
  always_comb begin
    st_r   = chme_pkg::ST_OK;
    dout_r = '0;
    case (op_r)
      chme_pkg::OP_INSERT: begin
        if (found) begin
          if (hit_word.data != '0 && hit_word.data != data_r) st_r = chme_pkg::ST_OVERWRITE;
        end else if (free_top == '0) begin
          st_r = chme_pkg::ST_FULL;
        end
      end
      chme_pkg::OP_REMOVE: if (!found) st_r = chme_pkg::ST_NOT_FOUND;
      chme_pkg::OP_LOOKUP: begin
        if (found) dout_r = hit_word.data;
        else       st_r   = chme_pkg::ST_NOT_FOUND;
      end
      default: ;
    endcase
  end

  // count as it stands after this request
  always_comb begin
    count32 = 32'(count);
    if (state == chme_pkg::S_ACT && op_r == chme_pkg::OP_REMOVE && found && count != '0) begin
      count32 = 32'(count) - 32'd1;
    end else if (state == chme_pkg::S_ALLOC && op_r == chme_pkg::OP_INSERT) begin
      count32 = 32'(count) + 32'd1;
    end
  end

  assign res.status = (state == chme_pkg::S_ALLOC) ? chme_pkg::ST_OK : st_r;
  assign res.data   = (state == chme_pkg::S_ALLOC) ? '0 : dout_r;
  assign res.count  = count32[chme_pkg::COUNT_W-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= chme_pkg::S_INIT;
      sweep    <= '0;
      free_top <= CW'(POOL_NODES);
      count    <= '0;
    end else begin
      state <= state_next;
      if (state == chme_pkg::S_INIT) begin
        sweep <= sweep + SW'(1);
      end
      if (state == chme_pkg::S_ACT && op_r == chme_pkg::OP_INSERT && !found &&
          free_top != '0) begin
        free_top <= free_top - CW'(1);
      end
      if (state == chme_pkg::S_ACT && res_ready && op_r == chme_pkg::OP_REMOVE && found) begin
        if (free_top < CW'(POOL_NODES)) free_top <= free_top + CW'(1);
        if (count != '0) count <= count - CW'(1);
      end
      if (state == chme_pkg::S_ALLOC && res_ready && op_r == chme_pkg::OP_INSERT) begin
        count <= count + CW'(1);
      end
    end
  end

endmodule

// File: rtl/core/chained_hash_map_engine.sv
// Sequence: a taken request passes S_HASH (skipped for a power-of-two bucket count),
// S_HEAD_RD, S_HEAD, one S_WALK step per chain node read (one node-memory read per node)
// and S_ACT, plus S_ALLOC for an insert of a new key; out_valid then rises from a register.
// Throughput: one request at a time; the next is taken the cycle after the result is posted.
// Reset: sync, active high; then a clearing pass that sweeps max(BUCKETS, POOL_NODES) addresses
// empties every bucket and refills the free stack, with in_ready low throughout.
module chained_hash_map_engine #(
  parameter int unsigned BUCKETS    = chme_pkg::BUCKETS_DEFAULT,
  parameter int unsigned POOL_NODES = chme_pkg::POOL_NODES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      op,
  input  logic [chme_pkg::KEY_W-1:0]      key,
  input  logic [chme_pkg::DATA_W-1:0]     data_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [chme_pkg::DATA_W-1:0]     data_out,
  output logic [chme_pkg::COUNT_W-1:0]    entry_count
);

  `include "chained_hash_map_engine_assert.svh"

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned IW = $clog2(POOL_NODES);
  localparam int unsigned NW = chme_pkg::KEY_W + chme_pkg::DATA_W + 1 + IW;

  logic              res_valid, res_ready;
  chme_pkg::result_t res;

  logic          b_we, n_we, f_we;
  logic [BW-1:0] b_addr;
  logic [IW:0]   b_wdata, b_rdata;
  logic [IW-1:0] n_addr;
  logic [NW-1:0] n_wdata, n_rdata;
  logic [IW-1:0] f_addr, f_wdata, f_rdata;

  chme_seq #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES)) u_seq (
    .clk, .rst, .in_valid, .in_ready, .op, .key, .data_in,
    .res_valid, .res_ready, .res,
    .b_we, .b_addr, .b_wdata, .b_rdata,
    .n_we, .n_addr, .n_wdata, .n_rdata,
    .f_we, .f_addr, .f_wdata, .f_rdata
  );

  // bucket heads: valid bit and node index
  chme_ram #(.WIDTH(IW + 1), .DEPTH(BUCKETS)) u_bucket_ram (
    .clk, .we(b_we), .addr(b_addr), .wdata(b_wdata), .rdata(b_rdata)
  );

  // nodes: key, data, link valid, link
  chme_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_node_ram (
    .clk, .we(n_we), .addr(n_addr), .wdata(n_wdata), .rdata(n_rdata)
  );

  // free node stack
  chme_ram #(.WIDTH(IW), .DEPTH(POOL_NODES)) u_free_ram (
    .clk, .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
  );

  // output word register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status      <= res.status;
      data_out    <= res.data;
      entry_count <= res.count;
    end
  end

  `CHME_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")
  `CHME_ASSERT_NEXT(a_one_result, res_valid && res_ready, !res_valid, "result repeated")
  `CHME_ASSERT_SAME(a_data_only_ok, res_valid && res.data != '0,
                    res.status == chme_pkg::ST_OK, "data with error status")

endmodule
